// ----- src/xild_pkg.sv -----
// Shared types, constants and opcode tables for the x86 instruction length decoder.
package xild_pkg;

	localparam int DEF_LENGTH_LIMIT = 255;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_ESC   = 3'd1;
	localparam logic [2:0] PH_GRP   = 3'd2;
	localparam logic [2:0] PH_MODRM = 3'd3;
	localparam logic [2:0] PH_SIB   = 3'd4;
	localparam logic [2:0] PH_TAIL  = 3'd5;

	localparam logic [7:0] OP_ESCAPE  = 8'h0F;
	localparam logic [7:0] OP_OPSIZE  = 8'h66;
	localparam logic [7:0] OP_ADSIZE  = 8'h67;
	localparam logic [6:0] GRP_SPLIT  = 7'd40;
	localparam int         GRP_COUNT  = 56;

	// one result, last field in the low bits
	typedef struct packed {
		logic [7:0]  sib_offset;
		logic        sib_found;
		logic [7:0]  modrm_offset;
		logic        modrm_found;
		logic [7:0]  rex_offset;
		logic        rex_found;
		logic        known_opcode;
		logic        group_opcode;
		logic        had_prefix;
		logic [7:0]  length;
		logic [11:0] opcode;
	} res_t;

	localparam int RES_W = $bits(res_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  opsz;
		logic [3:0]  asz;
		logic [7:0]  rex;
		logic        pfx;
		logic [11:0] op;
		logic [7:0]  typ;
		logic [7:0]  cnt;
		logic [7:0]  skip;
		logic [7:0]  modrm;
		logic        grp;
		logic        rexf;
		logic [7:0]  rexo;
		logic        mf;
		logic [7:0]  mo;
		logic        sf;
		logic [7:0]  so;
	} dstate_t;

	typedef struct packed {
		dstate_t st;
		logic    emit;
		res_t    r;
	} step_t;

	// write request from the decoder into the result queue
	typedef struct packed {
		logic wr0;
		logic wr1;
		res_t d0;
		res_t d1;
	} qwr_t;

	localparam logic [7:0] OP_KIND [0:511] = '{
		8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h01,8'h01, 8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h01,8'h00,
		8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h01,8'h01, 8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h01,8'h01,
		8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h00,8'h01, 8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h00,8'h01,
		8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h00,8'h01, 8'h23,8'h21,8'h23,8'h21,8'h09,8'h05,8'h00,8'h01,
		8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
		8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,8'h41, 8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,8'h41,
		8'h01,8'h01,8'h21,8'h21,8'h00,8'h00,8'h00,8'h00, 8'h45,8'h25,8'h49,8'h29,8'h03,8'h01,8'h03,8'h01,
		8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09, 8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,
		8'h27,8'h25,8'h27,8'h29,8'h23,8'h21,8'h23,8'h21, 8'h23,8'h21,8'h23,8'h21,8'h21,8'h21,8'h21,8'h80,
		8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01, 8'h01,8'h01,8'h05,8'h01,8'h41,8'h41,8'h01,8'h01,
		8'h0F,8'h0D,8'h0F,8'h0D,8'h03,8'h01,8'h03,8'h01, 8'h09,8'h05,8'h03,8'h01,8'h03,8'h01,8'h03,8'h01,
		8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07, 8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,8'h05,
		8'h27,8'h29,8'h01,8'h01,8'h21,8'h21,8'h27,8'h25, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h09,8'h01,8'h01,
		8'h23,8'h21,8'h23,8'h21,8'h09,8'h09,8'h01,8'h01, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09,8'h09, 8'h05,8'h05,8'h05,8'h09,8'h03,8'h01,8'h03,8'h01,
		8'h00,8'h01,8'h00,8'h00,8'h01,8'h01,8'h88,8'h90, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h98,8'hA0,
		8'h00,8'hA8,8'h00,8'h00,8'h00,8'h01,8'h01,8'h01, 8'h01,8'h01,8'h00,8'h01,8'h00,8'h21,8'h01,8'h00,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h21,8'h21,8'h21,8'h21,8'h00,8'h00,8'h00,8'h00, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h21,8'h00,8'h00,8'h00,8'h21,8'h21,8'h21,8'h00, 8'h21,8'h21,8'h00,8'h00,8'h21,8'h21,8'h21,8'h21,
		8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h01,8'h01,8'h01,8'h21,8'h29,8'h21,8'h00,8'h00, 8'h01,8'h01,8'h01,8'h21,8'h29,8'h21,8'h21,8'h21,
		8'h23,8'h21,8'h00,8'h21,8'h00,8'h00,8'h23,8'h21, 8'h21,8'h00,8'h29,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h21,8'h21,8'h00,8'h21,8'h00,8'h00,8'h00,8'h21, 8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21, 8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

	localparam logic [7:0] GRP_KIND [0:55] = '{
		8'h61,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h27,8'h27,8'h23,8'h23,8'h23,8'h23,8'h23,8'h23,
		8'h25,8'h25,8'h21,8'h21,8'h21,8'h21,8'h21,8'h21,
		8'h23,8'h23,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h21,8'h21,8'h61,8'h21,8'h61,8'h21,8'h61,8'h00,
		8'h00,8'h00,8'h21,8'h21,8'h21,8'h00,8'h21,8'h23,
		8'h21,8'h00,8'h00,8'h21,8'h21,8'h00,8'h21,8'h00
	};

endpackage

// ----- src/xild_dec.sv -----
// Front end: per-byte decode state machine, produces up to two results per beat.
module xild_dec import xild_pkg::*; #(
	parameter int LENGTH_LIMIT = DEF_LENGTH_LIMIT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       long_mode,
	input  logic       take_byte,
	input  logic [7:0] code_byte,
	output qwr_t       qwr
);

	localparam logic [7:0] LIM = 8'(LENGTH_LIMIT);

	dstate_t st_q;
	dstate_t st_d;
	step_t   a0;
	step_t   a1;

	function automatic logic [7:0] f_here(logic [7:0] c);
		return (c < LIM) ? c : LIM - 8'd1;
	endfunction

	function automatic logic [7:0] f_inc(logic [7:0] c);
		return (c < LIM) ? c + 8'd1 : c;
	endfunction

	function automatic dstate_t f_begin(logic lm);
		dstate_t s;
		s = '0;
		s.phase = PH_START;
		s.opsz = 4'd4;
		s.asz = lm ? 4'd8 : 4'd4;
		return s;
	endfunction

	function automatic res_t f_emit(dstate_t s);
		res_t r;
		r.opcode = s.op;
		r.length = s.cnt;
		r.had_prefix = s.pfx;
		r.group_opcode = s.grp;
		r.known_opcode = (s.typ != 8'd0);
		r.rex_found = s.rexf;
		r.rex_offset = s.rexo;
		r.modrm_found = s.mf;
		r.modrm_offset = s.mo;
		r.sib_found = s.sf;
		r.sib_offset = s.so;
		return r;
	endfunction

	function automatic logic [7:0] f_tail(dstate_t s, logic [7:0] t);
		logic [7:0] n;
		logic [3:0] cap;
		cap = (s.opsz == 4'd8) ? 4'd4 : s.opsz;
		n = 8'd0;
		if (s.op == 12'h0C8)
			n = 8'd3;
		else if (s.op == 12'h09A || s.op == 12'h0C2 || s.op == 12'h0CA || s.op == 12'h0EA)
			n = 8'd2;
		else if (s.op >= 12'hF80 && s.op <= 12'hF8F)
			n = {4'd0, cap};
		case (t[4:2])
			3'b001: begin
				if (t[1])
					n = n + 8'd1;
				else if (s.op >= 12'h0B8 && s.op <= 12'h0BF)
					n = n + {4'd0, s.opsz};
				else
					n = n + {4'd0, cap};
			end
			3'b010: n = n + 8'd1;
			3'b011: n = n + {4'd0, s.asz};
			default: n = n;
		endcase
		return n;
	endfunction

	function automatic dstate_t f_settle(dstate_t s, logic [7:0] t, logic lm);
		dstate_t o;
		o = s;
		o.typ = t;
		if (lm && t[6])
			o.opsz = 4'd8;
		o.skip = f_tail(o, t);
		return o;
	endfunction

	function automatic step_t f_close(dstate_t s, logic lm);
		step_t o;
		o.st = s;
		o.emit = 1'b0;
		o.r = f_emit(s);
		if (s.skip == 8'd0) begin
			o.emit = 1'b1;
			o.st = f_begin(lm);
		end else begin
			o.st.phase = PH_TAIL;
		end
		return o;
	endfunction

	function automatic step_t f_modrm(dstate_t s, logic [7:0] b, logic lm);
		dstate_t w;
		step_t o;
		logic [7:0] disp;
		w = s;
		disp = 8'd0;
		w.mf = 1'b1;
		w.mo = f_here(w.cnt);
		w.cnt = f_inc(w.cnt);
		w.modrm = b;
		o.st = w;
		o.emit = 1'b0;
		o.r = f_emit(w);
		if (b[7:6] != 2'd3) begin
			if (w.asz == 4'd2) begin
				if (b[7:6] == 2'd0)
					disp = (b[2:0] == 3'd6) ? 8'd2 : 8'd0;
				else
					disp = (b[7:6] == 2'd1) ? 8'd1 : 8'd2;
			end else if (b[2:0] == 3'd4) begin
				w.phase = PH_SIB;
				o.st = w;
				return o;
			end else begin
				if (b[7:6] == 2'd0)
					disp = (b[2:0] == 3'd5) ? 8'd4 : 8'd0;
				else
					disp = (b[7:6] == 2'd1) ? 8'd1 : 8'd4;
			end
		end
		w.skip = w.skip + disp;
		return f_close(w, lm);
	endfunction

	function automatic step_t f_type(dstate_t s, logic [7:0] t, logic lm);
		dstate_t w;
		step_t o;
		w = s;
		o.st = w;
		o.emit = 1'b0;
		o.r = f_emit(w);
		if (t[7]) begin
			o.st.typ = t;
			o.st.phase = PH_GRP;
			return o;
		end
		if (t == 8'd0) begin
			w.typ = 8'd0;
			o.r = f_emit(w);
			o.emit = 1'b1;
			o.st = f_begin(lm);
			return o;
		end
		w = f_settle(w, t, lm);
		if (t[5]) begin
			w.phase = PH_MODRM;
			o.st = w;
			o.r = f_emit(w);
			return o;
		end
		return f_close(w, lm);
	endfunction

	function automatic step_t f_start(dstate_t s, logic [7:0] b, logic lm);
		dstate_t w;
		step_t o;
		logic [7:0] off;
		w = s;
		if (w.cnt == 8'd0)
			w.asz = lm ? 4'd8 : 4'd4;
		off = f_here(w.cnt);
		w.cnt = f_inc(w.cnt);
		o.emit = 1'b0;
		case (b)
			OP_OPSIZE: begin
				w.opsz = w.opsz ^ 4'd6;
				w.rex = 8'd0;
				w.pfx = 1'b1;
			end
			OP_ADSIZE: begin
				w.asz = w.asz ^ (lm ? 4'd12 : 4'd6);
				w.rex = 8'd0;
				w.pfx = 1'b1;
			end
			8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0, 8'hF2, 8'hF3: begin
				w.rex = 8'd0;
				w.pfx = 1'b1;
			end
			default: begin
				if (lm && b[7:4] == 4'h4) begin
					w.rex = b;
					w.rexf = 1'b1;
					w.rexo = off;
					w.pfx = 1'b1;
				end else begin
					if (w.rex[3])
						w.opsz = 4'd8;
					if (b == OP_ESCAPE) begin
						w.op = {4'd0, OP_ESCAPE};
						w.phase = PH_ESC;
					end else begin
						w.op = {4'd0, b};
						return f_type(w, OP_KIND[{1'b0, b}], lm);
					end
				end
			end
		endcase
		o.st = w;
		o.r = f_emit(w);
		return o;
	endfunction

	always_comb begin
		dstate_t w;
		logic [7:0] idx;
		logic [7:0] t;
		logic [7:0] disp;
		w = st_q;
		idx = 8'd0;
		t = 8'd0;
		disp = 8'd0;
		a1 = '0;
		a0.st = st_q;
		a0.emit = 1'b0;
		a0.r = f_emit(st_q);
		case (st_q.phase)
			PH_START: a0 = f_start(st_q, code_byte, long_mode);
			PH_ESC: begin
				w.cnt = f_inc(w.cnt);
				w.op = {4'hF, code_byte};
				a0 = f_type(w, OP_KIND[{1'b1, code_byte}], long_mode);
			end
			PH_GRP: begin
				idx = {1'b0, st_q.typ[6:0]} + {5'd0, code_byte[5:3]};
				if (st_q.typ[6:0] == GRP_SPLIT && code_byte[7:6] == 2'd3)
					idx = idx + 8'd8;
				t = (idx < 8'(GRP_COUNT)) ? GRP_KIND[idx[5:0]] : 8'd0;
				w.grp = 1'b1;
				if (t == 8'd0) begin
					// unknown group member: close before ModRM, redecode this byte
					w.mf = 1'b1;
					w.mo = f_here(w.cnt);
					w.typ = 8'd0;
					a0.emit = 1'b1;
					a0.r = f_emit(w);
					a1 = f_start(f_begin(long_mode), code_byte, long_mode);
					a0.st = a1.st;
				end else begin
					a0 = f_modrm(f_settle(w, t, long_mode), code_byte, long_mode);
				end
			end
			PH_MODRM: a0 = f_modrm(st_q, code_byte, long_mode);
			PH_SIB: begin
				w.sf = 1'b1;
				w.so = f_here(w.cnt);
				w.cnt = f_inc(w.cnt);
				if (w.modrm[7:6] == 2'd0)
					disp = (code_byte[2:0] == 3'd5) ? 8'd4 : 8'd0;
				else
					disp = (w.modrm[7:6] == 2'd1) ? 8'd1 : 8'd4;
				w.skip = w.skip + disp;
				a0 = f_close(w, long_mode);
			end
			PH_TAIL: begin
				w.cnt = f_inc(w.cnt);
				if (w.skip != 8'd0)
					w.skip = w.skip - 8'd1;
				a0 = f_close(w, long_mode);
			end
			default: a0.st = f_begin(long_mode);
		endcase
		st_d = a0.st;
	end

	assign qwr.wr0 = take_byte && a0.emit;
	assign qwr.wr1 = take_byte && a1.emit;
	assign qwr.d0 = a0.r;
	assign qwr.d1 = a1.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= f_begin(1'b0);
		end else if (take_byte) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTHESIS
	a_two_only_from_group: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr1 |-> (st_q.phase == PH_GRP))
		else $error("second result outside group redecode");
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr0 |-> (qwr.d0.length != 8'd0))
		else $error("result with zero length");
	// group redecode keeps the re-read byte, so it is left out here
	a_fresh_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(qwr.wr0 && st_q.phase != PH_GRP) |=> (st_q.phase == PH_START && st_q.cnt == 8'd0))
		else $error("decode state not restarted after result");
`endif

endmodule

// ----- src/xild_queue.sv -----
// Result queue between decoder and output port; takes up to two beats per cycle.
module xild_queue import xild_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  qwr_t        qwr,
	output logic        room,
	output logic        rd_valid,
	input  logic        rd_ready,
	output res_t        rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	res_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          pop;
	logic [CW-1:0] nwr;

	assign pop = rd_valid && rd_ready;
	assign nwr = CW'(qwr.wr0) + CW'(qwr.wr1);
	assign rd_valid = (cnt_q != '0);
	assign rd_data = mem_q[rp_q];
	// two free slots needed: one byte may close two instructions
	assign room = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (qwr.wr0)
			mem_q[wp_q] <= qwr.d0;
		if (qwr.wr1)
			mem_q[AW'(wp_q + AW'(1))] <= qwr.d1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= AW'(wp_q + AW'(nwr));
			if (pop)
				rp_q <= AW'(rp_q + AW'(1));
			cnt_q <= cnt_q + nwr - CW'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("result queue overflow");
	a_wr_order: assert property (@(posedge clk) disable iff (!arst_n)
		qwr.wr1 |-> qwr.wr0)
		else $error("second slot written without first");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(qwr.wr0 && !pop) |=> (cnt_q != '0))
		else $error("queue count lost a write");
`endif

endmodule

// ----- src/x86_instruction_length_decoder.sv -----
// Top level of the x86 instruction length decoder.
// Usage: code bytes enter on the s_axis channel, one byte per beat. Each
// accepted byte is decoded in the cycle it is taken; when it completes an
// instruction, a result beat describing that instruction is queued and shows
// on m_axis from the next cycle on. Throughput: one byte per cycle while
// the queue has room. A byte may close two instructions (an unknown group
// member followed by a byte that is itself a full instruction); both results
// go into a four-entry queue and leave one per cycle while m_axis_tready is
// high. s_axis_tready drops only while fewer than two queue slots are free, so
// a stalled receiver backs the input up after the queue fills; nothing is lost.
// cfg_we/cfg_wdata set long mode (1 = 64-bit code); write it while idle.
// Reset (arst_n low) clears the decode state, empties the queue and selects
// 32-bit mode.
module x86_instruction_length_decoder import xild_pkg::*; #(
	parameter int LENGTH_LIMIT = DEF_LENGTH_LIMIT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,      // long_mode
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // code_byte
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// opcode[11:0] length[19:12] had_prefix[20] group_opcode[21]
	// known_opcode[22] rex_found[23] rex_offset[31:24] modrm_found[32]
	// modrm_offset[40:33] sib_found[41] sib_offset[49:42], zero above
	output logic [TDATA_W-1:0] m_axis_tdata
);

	logic long_mode_q;
	logic room;
	logic take_byte;
	qwr_t qwr;
	res_t head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			long_mode_q <= 1'b0;
		else if (cfg_we)
			long_mode_q <= cfg_wdata;
	end

	assign s_axis_tready = room;
	assign take_byte = s_axis_tvalid && room;

	xild_dec #(.LENGTH_LIMIT(LENGTH_LIMIT)) u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.long_mode (long_mode_q),
		.take_byte (take_byte),
		.code_byte (s_axis_tdata),
		.qwr       (qwr)
	);

	xild_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.qwr      (qwr),
		.room     (room),
		.rd_valid (m_axis_tvalid),
		.rd_ready (m_axis_tready),
		.rd_data  (head)
	);

	assign m_axis_tdata = TDATA_W'(head);

endmodule

// ----- test/xild_checker.sv -----
// Checker for the length decoder: predicts results from accepted code bytes and compares.
module xild_checker import xild_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,
	output int                 errors,
	output int                 pending,
	output int                 checked
);
	localparam int LIM = DEF_LENGTH_LIMIT;
	localparam logic [11:0] OP_ENTER = 12'h0C8;
	localparam logic [11:0] OP_CALLF = 12'h09A;
	localparam logic [11:0] OP_RETN  = 12'h0C2;
	localparam logic [11:0] OP_RETF  = 12'h0CA;
	localparam logic [11:0] OP_JMPF  = 12'h0EA;
	localparam logic [11:0] OP_JCC_LO = 12'hF80;
	localparam logic [11:0] OP_JCC_HI = 12'hF8F;
	localparam logic [11:0] OP_MOVI_LO = 12'h0B8;
	localparam logic [11:0] OP_MOVI_HI = 12'h0BF;

	// decoder shadow state
	logic        lm;
	logic [2:0]  ph;
	logic [3:0]  opsz, asz;
	logic [7:0]  rexv;
	logic        pfx;
	logic [11:0] op;
	logic [7:0]  typ, cnt, skip, mrm;
	logic        grp, rexf, mf, sf;
	logic [7:0]  rexo, mo, so;

	res_t expected_results[$];

	function void restart();
		ph = PH_START; opsz = 4; asz = lm ? 4'd8 : 4'd4;
		rexv = 0; pfx = 0; op = 0; typ = 0; cnt = 0; skip = 0; mrm = 0;
		grp = 0; rexf = 0; rexo = 0; mf = 0; mo = 0; sf = 0; so = 0;
	endfunction

	function logic [7:0] cur_off();
		return (cnt < LIM) ? cnt : 8'(LIM - 1);
	endfunction

	function logic [7:0] take_off();
		logic [7:0] o;
		o = cur_off();
		if (cnt < LIM) cnt++;
		return o;
	endfunction

	function res_t snap();
		res_t r;
		r = '0;
		r.opcode = op; r.length = cnt; r.had_prefix = pfx; r.group_opcode = grp;
		r.known_opcode = (typ != 0); r.rex_found = rexf; r.rex_offset = rexo;
		r.modrm_found = mf; r.modrm_offset = mo; r.sib_found = sf; r.sib_offset = so;
		return r;
	endfunction

	function logic [7:0] tail_len(input logic [7:0] t);
		int n;
		int capped;
		n = 0;
		capped = (opsz == 8) ? 4 : opsz;
		if (op == OP_ENTER) n += 3;
		else if (op == OP_CALLF || op == OP_RETN || op == OP_RETF || op == OP_JMPF) n += 2;
		else if (op >= OP_JCC_LO && op <= OP_JCC_HI) n += capped;
		case (t & 8'h1C)
			8'h04: begin
				if (t[1]) n += 1;
				else if (op >= OP_MOVI_LO && op <= OP_MOVI_HI) n += opsz;
				else n += capped;
			end
			8'h08: n += 1;
			8'h0C: n += asz;
			default: ;
		endcase
		return 8'(n);
	endfunction

	function void settle(input logic [7:0] t);
		typ = t;
		if (lm && t[6]) opsz = 8;
		skip = tail_len(t);
	endfunction

	function bit close_or_wait(output res_t r);
		r = '0;
		if (skip == 0) begin
			r = snap();
			restart();
			return 1;
		end
		ph = PH_TAIL;
		return 0;
	endfunction

	function bit on_modrm(input logic [7:0] b, output res_t r);
		int disp;
		disp = 0;
		r = '0;
		mf = 1; mo = take_off(); mrm = b;
		if (b[7:6] != 2'd3) begin
			if (asz == 2) begin
				disp = (b[7:6] == 0) ? ((b[2:0] == 6) ? 2 : 0) : ((b[7:6] == 1) ? 1 : 2);
			end else begin
				if (b[2:0] == 4) begin
					ph = PH_SIB;
					return 0;
				end
				disp = (b[7:6] == 0) ? ((b[2:0] == 5) ? 4 : 0) : ((b[7:6] == 1) ? 1 : 4);
			end
		end
		skip = skip + 8'(disp);
		return close_or_wait(r);
	endfunction

	function bit on_type(input logic [7:0] t, output res_t r);
		r = '0;
		if (t[7]) begin
			typ = t; ph = PH_GRP;
			return 0;
		end
		if (t == 0) begin
			typ = 0; r = snap(); restart();
			return 1;
		end
		settle(t);
		if (t[5]) begin
			ph = PH_MODRM;
			return 0;
		end
		return close_or_wait(r);
	endfunction

	function bit start_byte(input logic [7:0] b, output res_t r);
		logic [7:0] off;
		r = '0;
		if (cnt == 0) asz = lm ? 4'd8 : 4'd4;
		off = take_off();
		if (b == OP_OPSIZE) begin
			opsz ^= 4'd6; rexv = 0; pfx = 1;
			return 0;
		end
		if (b == OP_ADSIZE) begin
			asz ^= lm ? 4'd12 : 4'd6; rexv = 0; pfx = 1;
			return 0;
		end
		case (b)
			8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0, 8'hF2, 8'hF3: begin
				rexv = 0; pfx = 1;
				return 0;
			end
			default: ;
		endcase
		if (lm && b[7:4] == 4'h4) begin
			rexv = b; rexf = 1; rexo = off; pfx = 1;
			return 0;
		end
		if (rexv[3]) opsz = 8;
		if (b == OP_ESCAPE) begin
			op = 12'(OP_ESCAPE); ph = PH_ESC;
			return 0;
		end
		op = 12'(b);
		return on_type(OP_KIND[b], r);
	endfunction

	function int decode(input logic [7:0] b, output res_t r0, output res_t r1);
		int idx;
		logic [7:0] t;
		logic [7:0] dummy;
		int disp;
		r0 = '0; r1 = '0;
		case (ph)
			PH_START: return start_byte(b, r0);
			PH_ESC: begin
				dummy = take_off();
				op = {4'hF, b};
				return on_type(OP_KIND[256 + b], r0);
			end
			PH_GRP: begin
				idx = (typ & 8'h7F) + b[5:3];
				if ((typ & 8'h7F) == GRP_SPLIT && b[7:6] == 2'd3) idx += 8;
				t = (idx < GRP_COUNT) ? GRP_KIND[idx] : 8'h00;
				grp = 1;
				if (t == 0) begin
					// unknown group member: close before ModRM, re-decode the byte
					mf = 1; mo = cur_off(); typ = 0;
					r0 = snap();
					restart();
					return 1 + start_byte(b, r1);
				end
				settle(t);
				return on_modrm(b, r0);
			end
			PH_MODRM: return on_modrm(b, r0);
			PH_SIB: begin
				sf = 1; so = take_off();
				disp = (mrm[7:6] == 0) ? ((b[2:0] == 5) ? 4 : 0) : ((mrm[7:6] == 1) ? 1 : 4);
				skip = skip + 8'(disp);
				return close_or_wait(r0);
			end
			PH_TAIL: begin
				dummy = take_off();
				if (skip != 0) skip--;
				return close_or_wait(r0);
			end
			default: begin
				restart();
				return 0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t r0, r1, got, want;
		int k;
		if (!arst_n) begin
			lm = 0;
			restart();
			expected_results.delete();
			errors = 0; checked = 0; pending = 0;
		end else begin
			if (cfg_we) lm = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				k = decode(s_axis_tdata, r0, r1);
				if (k >= 1) expected_results.push_back(r0);
				if (k == 2) expected_results.push_back(r1);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = res_t'(m_axis_tdata[RES_W-1:0]);
				checked++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result beat %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got.opcode !== want.opcode || got.length !== want.length ||
					    got.had_prefix !== want.had_prefix ||
					    got.group_opcode !== want.group_opcode ||
					    got.known_opcode !== want.known_opcode ||
					    got.rex_found !== want.rex_found || got.rex_offset !== want.rex_offset ||
					    got.modrm_found !== want.modrm_found ||
					    got.modrm_offset !== want.modrm_offset ||
					    got.sib_found !== want.sib_found || got.sib_offset !== want.sib_offset ||
					    m_axis_tdata[TDATA_W-1:RES_W] !== '0) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected %p got %p (pad %h)", want, got,
								m_axis_tdata[TDATA_W-1:RES_W]);
					end
				end
			end
			pending = expected_results.size();
		end
	end
endmodule

// ----- test/testbench.sv -----
// Top of the length decoder testbench: clock, reset, code-byte stimulus and verdict.
module testbench;
	import xild_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_wdata = 0;
	logic               s_axis_tvalid = 0;
	logic               s_axis_tready;
	logic [7:0]         s_axis_tdata = 0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 0;
	logic [TDATA_W-1:0] m_axis_tdata;
	int                 errors, pending, checked;
	int                 cycles = 0;
	int                 bytes_sent = 0;
	int                 idle_left = 0;
	bit                 calm = 0;

	always #5 clk = ~clk;

	x86_instruction_length_decoder dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	xild_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.errors(errors), .pending(pending), .checked(checked)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver stalls in bursts
	always @(negedge clk) begin
		if (idle_left > 0) begin
			idle_left--;
			m_axis_tready <= 0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			idle_left = $urandom_range(0, 14);
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= 1;
		end
	end

	// called at a falling edge, returns at the next falling edge after the beat
	task automatic send_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic drain_and_set(input bit lm);
		s_axis_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we <= 1;
		cfg_wdata <= lm;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_list(input logic [7:0] seq[$]);
		foreach (seq[i]) send_byte(seq[i]);
	endtask

	// prefixes, opcode, then random body bytes the decoder consumes as it sees fit
	task automatic send_instr();
		logic [7:0] pfx_set[11] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'hF0,
			8'hF2, 8'hF3, OP_OPSIZE, OP_ADSIZE};
		int np;
		np = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
		repeat (np) send_byte(pfx_set[$urandom_range(0, 10)]);
		if ($urandom_range(0, 2) == 0) send_byte(8'h40 | 8'($urandom_range(0, 15)));
		if ($urandom_range(0, 3) == 0) send_byte(OP_ESCAPE);
		send_byte(8'($urandom));
		repeat ($urandom_range(0, 8)) send_byte(8'($urandom));
	endtask

	initial begin
		int n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		drain_and_set(0);
		// ModRM/SIB/disp32 forms, ENTER, Jcc with 16-bit operand, group opcode
		send_list('{8'h8B, 8'h05, 8'h11, 8'h22, 8'h33, 8'h44,
			8'h8B, 8'h04, 8'h25, 8'h01, 8'h02, 8'h03, 8'h04,
			8'hC8, 8'h00, 8'h10, 8'h00,
			OP_OPSIZE, OP_ESCAPE, 8'h85, 8'hFF, 8'hFF,
			8'hD6, 8'hFF, 8'h00});
		// unknown group member whose ModRM byte starts a new instruction itself
		send_list('{8'h8F, 8'hC8, 8'h8F, 8'h90, OP_ESCAPE, 8'h01, 8'hF8, OP_ADSIZE,
			8'h8B, 8'h46, 8'h01});
		// endless prefixes saturate the length
		repeat (262) send_byte(OP_OPSIZE);
		send_byte(8'h90);
		drain_and_set(1);
		// REX.W mov imm64, REX with SIB base 5, address toggle in long mode
		send_list('{8'h48, 8'hB8, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
			8'h4D, 8'h8B, 8'h04, 8'hED, 8'h00, 8'h00, 8'h00, 8'h80,
			OP_ADSIZE, 8'h8B, 8'h00, 8'h41, OP_OPSIZE, 8'hC7, 8'hC0, 8'h12, 8'h34,
			8'h8F, 8'hC0, 8'hFF, 8'h00});
		// mode switched mid-instruction
		send_list('{OP_ADSIZE, 8'h8B});
		drain_and_set(0);
		send_list('{8'h80, 8'h00, 8'h00});
		for (int ph = 0; ph < 4; ph++) begin
			drain_and_set(ph[0]);
			n = bytes_sent;
			while (bytes_sent - n < 220) begin
				if (ph == 3 && bytes_sent - n > 110) calm = 1;
				if ($urandom_range(0, 9) == 0) send_byte(8'($urandom));
				else send_instr();
			end
		end
		s_axis_tvalid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("covered %0d code bytes in 32- and 64-bit modes, %0d results checked",
			bytes_sent, checked);
		$display("directed: escapes, groups, SIB, saturation, double results");
		if (errors == 0 && pending == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
src/xild_pkg.sv
src/xild_dec.sv
src/xild_queue.sv
src/x86_instruction_length_decoder.sv
test/xild_checker.sv
test/testbench.sv
